FILE: rtl/interval_range_algebra_top_defines.svh
// ----------------------------------------------------------------------------
// interval range algebra assertion macros
// shared property forms for the checks at the end of the top module
// ----------------------------------------------------------------------------
`ifndef INTERVAL_RANGE_ALGEBRA_TOP_DEFINES_SVH
`define INTERVAL_RANGE_ALGEBRA_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define IRA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("interval range algebra check failed");

// next-cycle implication, disabled while reset is held
`define IRA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("interval range algebra check failed");

`endif

FILE: rtl/ira_pkg.sv
// ----------------------------------------------------------------------------
// interval range algebra package
// field widths, end kind and mode codes, shared structs and kind helpers
// ----------------------------------------------------------------------------
package ira_pkg;

    localparam int FIELD_W = 32;
    localparam int KIND_W  = 2;
    localparam int MODE_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_UNB = 2'd0,
        KIND_EXC = 2'd1,
        KIND_INC = 2'd2
    } kind_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_INTERSECT  = 2'd0,
        MODE_DIFF_LEFT  = 2'd1,
        MODE_DIFF_RIGHT = 2'd2,
        MODE_EXTEND     = 2'd3
    } mode_t;

    // decoded end flags
    typedef struct packed {
        logic bnd;
        logic inc;
    } end_t;

    // relations between a and b
    typedef struct packed {
        logic sb_ab;
        logic sb_ba;
        logic ea_ab;
        logic ea_ba;
        logic dl_ab;
        logic dl_ba;
        logic contains_ab;
        logic contains_ba;
        logic ovl_left;
        logic ovl_right;
        logic touch;
        logic hi_lo_eq;
    } rel_t;

    function automatic end_t decode_kind(logic [KIND_W-1:0] k);
        end_t e;
        e.bnd = (k != KIND_UNB);
        e.inc = (k >= KIND_INC);
        return e;
    endfunction

    function automatic logic [KIND_W-1:0] encode_kind(end_t e);
        logic [KIND_W-1:0] k;
        if (!e.bnd) begin
            k = KIND_UNB;
        end else if (e.inc) begin
            k = KIND_INC;
        end else begin
            k = KIND_EXC;
        end
        return k;
    endfunction

endpackage

FILE: rtl/ira_relate.sv
// ----------------------------------------------------------------------------
// interval range algebra relations
// compares the end keys of a and b and derives the interval relations
// ----------------------------------------------------------------------------
module ira_relate #(
    parameter int KEY_W = 32
) (
    input  logic signed [KEY_W-1:0] a_lo,
    input  logic signed [KEY_W-1:0] a_hi,
    input  logic signed [KEY_W-1:0] b_lo,
    input  logic signed [KEY_W-1:0] b_hi,
    input  ira_pkg::end_t           a_lo_f,
    input  ira_pkg::end_t           a_hi_f,
    input  ira_pkg::end_t           b_lo_f,
    input  ira_pkg::end_t           b_hi_f,
    output ira_pkg::rel_t           rel
);
    import ira_pkg::*;

    logic lo_lt, lo_eq, hi_gt, hi_eq;
    logic ahi_lt_blo, ahi_eq_blo, bhi_lt_alo, bhi_eq_alo;
    logic same_lo, same_hi;

    assign lo_lt      = (a_lo < b_lo);
    assign lo_eq      = (a_lo == b_lo);
    assign hi_gt      = (a_hi > b_hi);
    assign hi_eq      = (a_hi == b_hi);
    assign ahi_lt_blo = (a_hi < b_lo);
    assign ahi_eq_blo = (a_hi == b_lo);
    assign bhi_lt_alo = (b_hi < a_lo);
    assign bhi_eq_alo = (b_hi == a_lo);

    assign same_lo = (!a_lo_f.bnd && !b_lo_f.bnd) ||
                     (a_lo_f.bnd && b_lo_f.bnd && lo_eq && (a_lo_f.inc == b_lo_f.inc));
    assign same_hi = (!a_hi_f.bnd && !b_hi_f.bnd) ||
                     (a_hi_f.bnd && b_hi_f.bnd && hi_eq && (a_hi_f.inc == b_hi_f.inc));

    always_comb begin
        rel.sb_ab = !b_lo_f.bnd ? !a_lo_f.bnd :
                    (!a_lo_f.bnd || lo_lt || (lo_eq && a_lo_f.inc && !b_lo_f.inc));
        rel.sb_ba = !a_lo_f.bnd ? !b_lo_f.bnd :
                    (!b_lo_f.bnd || (!lo_lt && !lo_eq) ||
                     (lo_eq && b_lo_f.inc && !a_lo_f.inc));
        rel.ea_ab = !b_hi_f.bnd ? !a_hi_f.bnd :
                    (!a_hi_f.bnd || hi_gt || (hi_eq && a_hi_f.inc && !b_hi_f.inc));
        rel.ea_ba = !a_hi_f.bnd ? !b_hi_f.bnd :
                    (!b_hi_f.bnd || (!hi_gt && !hi_eq) ||
                     (hi_eq && b_hi_f.inc && !a_hi_f.inc));
        rel.dl_ab = a_hi_f.bnd && b_lo_f.bnd &&
                    (ahi_lt_blo || (ahi_eq_blo && (!a_hi_f.inc || !b_lo_f.inc)));
        rel.dl_ba = b_hi_f.bnd && a_lo_f.bnd &&
                    (bhi_lt_alo || (bhi_eq_alo && (!b_hi_f.inc || !a_lo_f.inc)));
        rel.contains_ab = (rel.sb_ab || same_lo) && (rel.ea_ab || same_hi);
        rel.contains_ba = (rel.sb_ba || same_lo) && (rel.ea_ba || same_hi);
        rel.ovl_left    = rel.sb_ab && !rel.ea_ab && !rel.dl_ab;
        rel.ovl_right   = rel.ea_ab && !rel.sb_ab && !rel.dl_ba;
        rel.touch       = (!a_hi_f.bnd && !b_lo_f.bnd) ||
                          (a_hi_f.bnd && b_lo_f.bnd && ahi_eq_blo);
        rel.hi_lo_eq    = ahi_eq_blo;
    end

endmodule

FILE: rtl/ira_select.sv
// ----------------------------------------------------------------------------
// interval range algebra result select
// picks the derived interval for the mode and formats its ends
// ----------------------------------------------------------------------------
module ira_select #(
    parameter int KEY_W = 32
) (
    input  logic [ira_pkg::MODE_W-1:0]         mode,
    input  logic signed [KEY_W-1:0]            a_lo,
    input  logic signed [KEY_W-1:0]            a_hi,
    input  logic signed [KEY_W-1:0]            b_lo,
    input  logic signed [KEY_W-1:0]            b_hi,
    input  ira_pkg::end_t                      a_lo_f,
    input  ira_pkg::end_t                      a_hi_f,
    input  ira_pkg::end_t                      b_lo_f,
    input  ira_pkg::end_t                      b_hi_f,
    input  ira_pkg::rel_t                      rel,
    output logic                               present,
    output logic signed [ira_pkg::FIELD_W-1:0] res_lo,
    output logic [ira_pkg::KIND_W-1:0]         res_lo_kind,
    output logic signed [ira_pkg::FIELD_W-1:0] res_hi,
    output logic [ira_pkg::KIND_W-1:0]         res_hi_kind
);
    import ira_pkg::*;

    logic signed [KEY_W-1:0] lo_key, hi_key;
    end_t                    lo_f, hi_f;

    always_comb begin
        present = 1'b0;
        lo_key  = a_lo;
        lo_f    = a_lo_f;
        hi_key  = a_hi;
        hi_f    = a_hi_f;
        case (mode_t'(mode))
            MODE_INTERSECT: begin
                if (rel.contains_ab) begin
                    present = 1'b1;
                    lo_key  = b_lo;
                    lo_f    = b_lo_f;
                    hi_key  = b_hi;
                    hi_f    = b_hi_f;
                end else if (rel.contains_ba) begin
                    present = 1'b1;
                end else if (rel.ovl_left) begin
                    present = 1'b1;
                    lo_key  = b_lo;
                    lo_f    = b_lo_f;
                end else if (rel.ovl_right) begin
                    present = 1'b1;
                    hi_key  = b_hi;
                    hi_f    = b_hi_f;
                end
            end
            MODE_DIFF_LEFT: begin
                if (rel.dl_ab) begin
                    present = 1'b1;
                end else if (rel.sb_ab && b_lo_f.bnd) begin
                    present  = 1'b1;
                    hi_key   = b_lo;
                    hi_f.bnd = 1'b1;
                    hi_f.inc = !b_lo_f.inc;
                end
            end
            MODE_DIFF_RIGHT: begin
                if (rel.dl_ba) begin
                    present = 1'b1;
                end else if (rel.ea_ab && b_hi_f.bnd) begin
                    present  = 1'b1;
                    lo_key   = b_hi;
                    lo_f.bnd = 1'b1;
                    lo_f.inc = !b_hi_f.inc;
                end
            end
            MODE_EXTEND: begin
                if (rel.dl_ab && rel.hi_lo_eq && (b_lo_f.inc || a_hi_f.inc)) begin
                    present = 1'b1;
                    hi_key  = b_hi;
                    hi_f    = b_hi_f;
                end
            end
            default: begin
                present = 1'b0;
            end
        endcase
    end

    // unbounded or missing ends read as zero
    assign res_lo      = (present && lo_f.bnd) ? FIELD_W'(lo_key) : '0;
    assign res_hi      = (present && hi_f.bnd) ? FIELD_W'(hi_key) : '0;
    assign res_lo_kind = present ? encode_kind(lo_f) : KIND_UNB;
    assign res_hi_kind = present ? encode_kind(hi_f) : KIND_UNB;

endmodule

FILE: rtl/interval_range_algebra_top.sv
// ----------------------------------------------------------------------------
// interval range algebra top
// relations of two intervals and one derived interval chosen by mode
// ----------------------------------------------------------------------------
// Each request is captured in an input register, evaluated by one pass of
// compare and select logic, and held in a result register until the result
// side takes it; a new request is taken every cycle while the result side
// keeps up. The single compare pass lies between the two registers; keys
// use the low KEY_WIDTH bits (at most 32) of each key port, sign extended.
module interval_range_algebra_top #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ira_pkg::MODE_W-1:0]         s_mode,
    input  logic signed [ira_pkg::FIELD_W-1:0] s_a_lo,
    input  logic [ira_pkg::KIND_W-1:0]         s_a_lo_kind,
    input  logic signed [ira_pkg::FIELD_W-1:0] s_a_hi,
    input  logic [ira_pkg::KIND_W-1:0]         s_a_hi_kind,
    input  logic signed [ira_pkg::FIELD_W-1:0] s_b_lo,
    input  logic [ira_pkg::KIND_W-1:0]         s_b_lo_kind,
    input  logic signed [ira_pkg::FIELD_W-1:0] s_b_hi,
    input  logic [ira_pkg::KIND_W-1:0]         s_b_hi_kind,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_present,
    output logic signed [ira_pkg::FIELD_W-1:0] m_res_lo,
    output logic [ira_pkg::KIND_W-1:0]         m_res_lo_kind,
    output logic signed [ira_pkg::FIELD_W-1:0] m_res_hi,
    output logic [ira_pkg::KIND_W-1:0]         m_res_hi_kind,
    output logic                               m_contains,
    output logic                               m_disjoint_left,
    output logic                               m_overlaps_left,
    output logic                               m_overlaps_right,
    output logic                               m_ends_touch
);
    import ira_pkg::*;
    `include "interval_range_algebra_top_defines.svh"

    localparam int KW = (KEY_WIDTH < FIELD_W) ? KEY_WIDTH : FIELD_W;

    // input stage
    logic                    in_vld_reg;
    logic [MODE_W-1:0]       mode_reg;
    logic signed [KW-1:0]    a_lo_reg, a_hi_reg, b_lo_reg, b_hi_reg;
    logic [KIND_W-1:0]       a_lo_kind_reg, a_hi_kind_reg, b_lo_kind_reg, b_hi_kind_reg;

    // result stage
    logic                    out_vld_reg;
    logic                    present_reg;
    logic signed [FIELD_W-1:0] res_lo_reg, res_hi_reg;
    logic [KIND_W-1:0]       res_lo_kind_reg, res_hi_kind_reg;
    logic                    contains_reg, disjoint_left_reg;
    logic                    overlaps_left_reg, overlaps_right_reg, ends_touch_reg;

    logic                    out_open, advance, take;
    end_t                    a_lo_f, a_hi_f, b_lo_f, b_hi_f;
    rel_t                    rel;
    logic                    present_next;
    logic signed [FIELD_W-1:0] res_lo_next, res_hi_next;
    logic [KIND_W-1:0]       res_lo_kind_next, res_hi_kind_next;

    assign out_open = !out_vld_reg || m_ready;
    assign advance  = in_vld_reg && out_open;
    assign s_ready  = !in_vld_reg || out_open;
    assign take     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (out_open) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            mode_reg      <= s_mode;
            a_lo_reg      <= s_a_lo[KW-1:0];
            a_lo_kind_reg <= s_a_lo_kind;
            a_hi_reg      <= s_a_hi[KW-1:0];
            a_hi_kind_reg <= s_a_hi_kind;
            b_lo_reg      <= s_b_lo[KW-1:0];
            b_lo_kind_reg <= s_b_lo_kind;
            b_hi_reg      <= s_b_hi[KW-1:0];
            b_hi_kind_reg <= s_b_hi_kind;
        end
    end

    assign a_lo_f = decode_kind(a_lo_kind_reg);
    assign a_hi_f = decode_kind(a_hi_kind_reg);
    assign b_lo_f = decode_kind(b_lo_kind_reg);
    assign b_hi_f = decode_kind(b_hi_kind_reg);

    ira_relate #(
        .KEY_W  (KW)
    ) u_relate (
        .a_lo   (a_lo_reg),
        .a_hi   (a_hi_reg),
        .b_lo   (b_lo_reg),
        .b_hi   (b_hi_reg),
        .a_lo_f (a_lo_f),
        .a_hi_f (a_hi_f),
        .b_lo_f (b_lo_f),
        .b_hi_f (b_hi_f),
        .rel    (rel)
    );

    ira_select #(
        .KEY_W       (KW)
    ) u_select (
        .mode        (mode_reg),
        .a_lo        (a_lo_reg),
        .a_hi        (a_hi_reg),
        .b_lo        (b_lo_reg),
        .b_hi        (b_hi_reg),
        .a_lo_f      (a_lo_f),
        .a_hi_f      (a_hi_f),
        .b_lo_f      (b_lo_f),
        .b_hi_f      (b_hi_f),
        .rel         (rel),
        .present     (present_next),
        .res_lo      (res_lo_next),
        .res_lo_kind (res_lo_kind_next),
        .res_hi      (res_hi_next),
        .res_hi_kind (res_hi_kind_next)
    );

    always_ff @(posedge aclk) begin
        if (advance) begin
            present_reg        <= present_next;
            res_lo_reg         <= res_lo_next;
            res_lo_kind_reg    <= res_lo_kind_next;
            res_hi_reg         <= res_hi_next;
            res_hi_kind_reg    <= res_hi_kind_next;
            contains_reg       <= rel.contains_ab;
            disjoint_left_reg  <= rel.dl_ab;
            overlaps_left_reg  <= rel.ovl_left;
            overlaps_right_reg <= rel.ovl_right;
            ends_touch_reg     <= rel.touch;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_present        = present_reg;
    assign m_res_lo         = res_lo_reg;
    assign m_res_lo_kind    = res_lo_kind_reg;
    assign m_res_hi         = res_hi_reg;
    assign m_res_hi_kind    = res_hi_kind_reg;
    assign m_contains       = contains_reg;
    assign m_disjoint_left  = disjoint_left_reg;
    assign m_overlaps_left  = overlaps_left_reg;
    assign m_overlaps_right = overlaps_right_reg;
    assign m_ends_touch     = ends_touch_reg;

    // checks
    `IRA_ASSERT_NEXT(a_stage_moves, aclk, aresetn, in_vld_reg && !out_vld_reg, out_vld_reg)
    `IRA_ASSERT_IMPL(a_ovl_excl, aclk, aresetn, m_valid, !(m_overlaps_left && m_overlaps_right))
    `IRA_ASSERT_IMPL(a_absent_zero, aclk, aresetn, m_valid && !m_present, m_res_lo == '0 && m_res_hi == '0 && m_res_lo_kind == KIND_UNB && m_res_hi_kind == KIND_UNB)
    `IRA_ASSERT_IMPL(a_unb_lo_zero, aclk, aresetn, m_valid && m_res_lo_kind == KIND_UNB, m_res_lo == '0)
    `IRA_ASSERT_IMPL(a_unb_hi_zero, aclk, aresetn, m_valid && m_res_hi_kind == KIND_UNB, m_res_hi == '0)

endmodule
